FILE: design/u8u16_pkg.sv
`timescale 1ns / 1ps
package u8u16_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
   localparam logic [20:0] SUPP_BASE        = 21'h10000;

   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } job_type;

   typedef struct packed {
      logic [2:0][15:0] units;
      logic [1:0]       count;
      logic             last;
   } unit_set_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = LEN_NONE;
      if (b[7:5] == 3'b110) begin
         len = LEN_TWO;
      end else if (b[7:4] == 4'b1110) begin
         len = LEN_THREE;
      end else if (b[7:3] == 5'b11110) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   function automatic logic [15:0] single_unit(input logic [7:0] b);
      logic [15:0] u;
      u = b[7] ? REPLACEMENT_UNIT : {8'h00, b};
      return u;
   endfunction

   function automatic unit_set_type decode_job(input job_type job);
      unit_set_type r;
      logic [2:0]   len;
      logic [20:0]  cp;
      logic [20:0]  off;
      r.units = {3{REPLACEMENT_UNIT}};
      r.count = 2'd1;
      r.last  = job.last;
      len     = lead_len(job.bytes[0]);
      cp      = 21'd0;
      off     = 21'd0;
      if (job.count == 3'd1) begin
         r.units[0] = single_unit(job.bytes[0]);
      end else if (job.count == len) begin
         case (len)
            LEN_TWO: begin
               cp = {10'd0, job.bytes[0][4:0], job.bytes[1][5:0]};
            end
            LEN_THREE: begin
               cp = {5'd0, job.bytes[0][3:0], job.bytes[1][5:0], job.bytes[2][5:0]};
            end
            LEN_FOUR: begin
               cp = {job.bytes[0][2:0], job.bytes[1][5:0], job.bytes[2][5:0],
                     job.bytes[3][5:0]};
            end
            default: begin
               cp = {5'd0, REPLACEMENT_UNIT};
            end
         endcase
         if (cp >= SUPP_BASE) begin
            off        = cp - SUPP_BASE;
            r.units[0] = HIGH_SURR_BASE + {5'd0, off[20:10]};
            r.units[1] = LOW_SURR_BASE + {6'd0, off[9:0]};
            r.count    = 2'd2;
         end else begin
            r.units[0] = cp[15:0];
         end
      end else begin
         r.units[0] = REPLACEMENT_UNIT;
         if (job.count == 3'd2) begin
            r.units[1] = single_unit(job.bytes[1]);
            r.count    = 2'd2;
         end else if (!job.bytes[1][7]) begin
            r.units[1] = {8'h00, job.bytes[1]};
            r.units[2] = single_unit(job.bytes[2]);
            r.count    = 2'd3;
         end else if (job.bytes[1][7:5] == 3'b110) begin
            r.units[1] = {5'd0, job.bytes[1][4:0], job.bytes[2][5:0]};
            r.count    = 2'd2;
         end else begin
            r.units[1] = REPLACEMENT_UNIT;
            r.units[2] = single_unit(job.bytes[2]);
            r.count    = 2'd3;
         end
      end
      return r;
   endfunction

endpackage

FILE: design/u8u16_front.sv
`timescale 1ns / 1ps
module u8u16_front
   import u8u16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       job_valid,
   output job_type    job,
   input  logic       job_ready
);

   logic [2:0][7:0] pend_ff;
   logic [1:0]      pcount_ff;
   logic [1:0]      pcount_in;
   logic [2:0]      slen_ff;
   logic [2:0]      slen_in;
   logic [2:0]      lead;
   logic [2:0]      n_sum;
   logic            hold;
   logic            accept;

   always_comb begin
      lead   = lead_len(req_in_byte);
      n_sum  = {1'b0, pcount_ff} + 3'd1;
      if (pcount_ff == 2'd0) begin
         hold = (lead != LEN_NONE) && !req_in_last;
      end else begin
         hold = (n_sum < slen_ff) && !req_in_last;
      end
      accept    = req_valid && job_ready;
      req_ready = job_ready;
      job_valid = req_valid && !hold;
      job.bytes[0] = (pcount_ff > 2'd0) ? pend_ff[0] : req_in_byte;
      job.bytes[1] = (pcount_ff > 2'd1) ? pend_ff[1] : req_in_byte;
      job.bytes[2] = (pcount_ff > 2'd2) ? pend_ff[2] : req_in_byte;
      job.bytes[3] = req_in_byte;
      job.count    = n_sum;
      job.last     = req_in_last;
   end

   always_comb begin
      pcount_in = pcount_ff;
      slen_in   = slen_ff;
      if (accept) begin
         if (hold) begin
            pcount_in = n_sum[1:0];
            if (pcount_ff == 2'd0) begin
               slen_in = lead;
            end
         end else begin
            pcount_in = 2'd0;
            slen_in   = LEN_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= 2'd0;
         slen_ff   <= LEN_NONE;
      end else begin
         pcount_ff <= pcount_in;
         slen_ff   <= slen_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (accept && hold && (pcount_ff == 2'(j))) begin
            pend_ff[j] <= req_in_byte;
         end
      end
   end

endmodule

FILE: design/u8u16_queue.sv
`timescale 1ns / 1ps
module u8u16_queue
   import u8u16_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         slots_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            push;
   logic            pop;

   always_comb begin
      push_ready = count_ff != CW'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_job    = slots_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/u8u16_back.sv
`timescale 1ns / 1ps
module u8u16_back
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_unit_last
);

   unit_set_type decoded;
   unit_set_type set_ff;
   logic         valid_ff;
   logic         valid_in;
   logic [1:0]   idx_ff;
   logic [1:0]   idx_in;
   logic         final_unit;
   logic         load;

   always_comb begin
      decoded    = decode_job(job);
      final_unit = idx_ff == (set_ff.count - 2'd1);
      job_ready  = !valid_ff || (rsp_ready && final_unit);
      load       = job_valid && job_ready;
      rsp_valid  = valid_ff;
      rsp_unit_last = set_ff.last && final_unit;
      case (idx_ff)
         2'd0:    rsp_code_unit = set_ff.units[0];
         2'd1:    rsp_code_unit = set_ff.units[1];
         2'd2:    rsp_code_unit = set_ff.units[2];
         default: rsp_code_unit = REPLACEMENT_UNIT;
      endcase
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_ready) begin
         if (final_unit) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         set_ff <= decoded;
      end
   end

endmodule

FILE: design/utf8_to_utf16_decoder_core.sv
`timescale 1ns / 1ps
// A finished sequence goes as one job into the job queue, and the output register loads
// it from there. Throughput: one byte per cycle while the queue has room; one code unit
// per cycle out of the output register while rsp_ready is high, so a byte that ends in 2
// or 3 units holds the output while the queue of QUEUE_DEPTH entries keeps taking bytes.
// Reset: synchronous, clears the pending sequence, the queue and the output valid.
module utf8_to_utf16_decoder_core
   import u8u16_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_unit_last
);

   job_type push_job;
   job_type pop_job;
   logic    push_valid;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   u8u16_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .job_valid   (push_valid),
      .job         (push_job),
      .job_ready   (push_ready)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   u8u16_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (pop_valid),
      .job_ready     (pop_ready),
      .job           (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_unit (rsp_code_unit),
      .rsp_unit_last (rsp_unit_last)
   );

`ifndef NO_ASSERTIONS
   a_last_byte_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_last) |-> (push_valid && push_ready && push_job.last))
      else $error("final byte did not flush a job");

   a_front_waits_queue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> push_ready)
      else $error("byte taken while job queue full");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_job_count_range: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |-> (push_job.count != 3'd0 && push_job.count <= LEN_FOUR))
      else $error("job byte count out of range");
`endif

endmodule

FILE: tb/utf8_to_utf16_decoder_core_tb.sv
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_core_tb;
   import u8u16_pkg::*;

   typedef struct packed {
      logic [15:0] unit;
      logic        last;
   } unit_entry_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [15:0] unit;
   } byte_row_type;

   localparam int DIRECTED_ROWS = 27;
   localparam int RANDOM_ITEMS  = 430;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_unit_last;

   unit_entry_type expected_units[$];
   unit_entry_type want;
   logic [7:0]     held_bytes[3];
   logic [1:0]     held_count = 2'd0;
   logic [2:0]     held_len = LEN_NONE;
   int             fail_count = 0;
   logic           steady = 1'b0;

   byte_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{8'h00, 1'b0, 1'b1, 16'h0000},
      '{8'h7F, 1'b1, 1'b1, 16'h007F},
      '{8'h80, 1'b0, 1'b1, REPLACEMENT_UNIT},
      '{8'hFF, 1'b0, 1'b1, REPLACEMENT_UNIT},
      '{8'hF8, 1'b1, 1'b1, REPLACEMENT_UNIT},
      '{8'hC0, 1'b1, 1'b1, REPLACEMENT_UNIT},
      '{8'hC3, 1'b0, 1'b0, 16'h0000},
      '{8'hA9, 1'b0, 1'b0, 16'h0000},
      '{8'hE2, 1'b0, 1'b0, 16'h0000},
      '{8'h82, 1'b0, 1'b0, 16'h0000},
      '{8'hAC, 1'b0, 1'b0, 16'h0000},
      '{8'hF0, 1'b0, 1'b0, 16'h0000},
      '{8'h9F, 1'b0, 1'b0, 16'h0000},
      '{8'h98, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b0, 1'b0, 16'h0000},
      '{8'hF7, 1'b0, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, 16'h0000},
      '{8'hBF, 1'b1, 1'b0, 16'h0000},
      '{8'hE0, 1'b0, 1'b0, 16'h0000},
      '{8'h41, 1'b1, 1'b0, 16'h0000},
      '{8'hF0, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b1, 1'b0, 16'h0000},
      '{8'hED, 1'b0, 1'b0, 16'h0000},
      '{8'hA0, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b1, 1'b0, 16'h0000}
   };

   utf8_to_utf16_decoder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_unit (rsp_code_unit),
      .rsp_unit_last (rsp_unit_last)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic int pause_len();
      int n;
      n = steady ? 0 : $urandom_range(0, 16);
      return n;
   endfunction

   function automatic logic [2:0] lead_span(input logic [7:0] b);
      logic [2:0] len;
      len = LEN_NONE;
      if (b[7:5] == 3'b110) begin
         len = LEN_TWO;
      end else if (b[7:4] == 4'b1110) begin
         len = LEN_THREE;
      end else if (b[7:3] == 5'b11110) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   task automatic transcode_byte(input logic [7:0] b, input logic last, output int produced);
      logic [7:0]     seq[4];
      logic [15:0]    units[8];
      logic [7:0]     c;
      logic [2:0]     len;
      logic [20:0]    cp;
      logic [20:0]    off;
      unit_entry_type u;
      int             n;
      int             i;
      int             k;
      int             j;
      produced = 0;
      if (held_count == 2'd0) begin
         len = lead_span(b);
         if (len != LEN_NONE && !last) begin
            held_bytes[0] = b;
            held_count = 2'd1;
            held_len = len;
            return;
         end
         seq[0] = b;
         n = 1;
      end else begin
         for (j = 0; j < held_count; j++) begin
            seq[j] = held_bytes[j];
         end
         seq[held_count] = b;
         n = held_count + 1;
         if (n < held_len && !last) begin
            held_bytes[held_count] = b;
            held_count = held_count + 2'd1;
            return;
         end
      end
      held_count = 2'd0;
      held_len = LEN_NONE;
      i = 0;
      k = 0;
      while (i < n) begin
         c = seq[i];
         len = lead_span(c);
         if (!c[7]) begin
            cp = {13'd0, c};
            i += 1;
         end else if (len == LEN_TWO && i + 1 < n) begin
            cp = {10'd0, c[4:0], seq[i+1][5:0]};
            i += 2;
         end else if (len == LEN_THREE && i + 2 < n) begin
            cp = {5'd0, c[3:0], seq[i+1][5:0], seq[i+2][5:0]};
            i += 3;
         end else if (len == LEN_FOUR && i + 3 < n) begin
            cp = {c[2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
            i += 4;
         end else begin
            cp = {5'd0, REPLACEMENT_UNIT};
            i += 1;
         end
         if (cp < SUPP_BASE) begin
            units[k] = cp[15:0];
            k += 1;
         end else begin
            off = cp - SUPP_BASE;
            units[k] = HIGH_SURR_BASE + {5'd0, off[20:10]};
            units[k+1] = LOW_SURR_BASE + {6'd0, off[9:0]};
            k += 2;
         end
      end
      if (k > 3) begin
         k = 3;
      end
      for (j = 0; j < k; j++) begin
         u.unit = units[j];
         u.last = last && (j == k - 1);
         expected_units.insert(expected_units.size(), u);
      end
      produced = k;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input logic [15:0] unit);
      int gap;
      int produced;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      transcode_byte(b, last, produced);
      if (typed && produced == 1) begin
         expected_units[expected_units.size() - 1].unit = unit;
      end
   endtask

   initial begin : stimulus
      logic [7:0] seq[4];
      int         nb;
      int         kind;
      int         sent;
      int         r;
      int         j;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         send_byte(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                   directed_rows[r].unit);
      end
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 40 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            nb = 1;
            seq[0] = 8'($urandom_range(0, 127));
         end else if (kind < 50) begin
            nb = 2;
            seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
         end else if (kind < 65) begin
            nb = 3;
            seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
         end else if (kind < 80) begin
            nb = 4;
            seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
         end else begin
            nb = 1;
            seq[0] = 8'($urandom_range(0, 255));
         end
         for (j = 1; j < nb; j++) begin
            seq[j] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : (8'h80 | 8'($urandom_range(0, 63)));
         end
         for (j = 0; j < nb; j++) begin
            send_byte(seq[j], $urandom_range(0, 9) == 0, 1'b0, 16'h0000);
            sent++;
         end
      end
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_units.size() == 0) begin
         $display("utf8_to_utf16_decoder_core_tb: done, clean");
      end else begin
         $display("utf8_to_utf16_decoder_core_tb: done, errors");
      end
      $finish;
   end

   initial begin : drain
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pause_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected unit: code %h last %b", rsp_code_unit, rsp_unit_last);
            end
         end else begin
            want = expected_units.pop_front();
            if (want.unit !== rsp_code_unit || want.last !== rsp_unit_last) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unit mismatch: expected code %h last %b, got code %h last %b",
                           want.unit, want.last, rsp_code_unit, rsp_unit_last);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("utf8_to_utf16_decoder_core_tb: done, errors");
      $finish;
   end

endmodule
